### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk_i, disabled while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form: when the antecedent holds, the consequent holds in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tpmc_pkg.sv
// ----------------------------------------------------------------------------
// tpmc_pkg
// Types, constants and the modular addition helper of the three-pass cipher core.
// ----------------------------------------------------------------------------
package tpmc_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_KEY_A   = 2'd1;
  localparam logic [1:0] REG_KEY_B   = 2'd2;

  localparam logic KEY_SEL_A = 1'b0;
  localparam logic KEY_SEL_B = 1'b1;

  localparam logic [1:0] STAGE_FIRST = 2'd0;
  localparam logic [1:0] STAGE_LAST  = 2'd3;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_ERROR,
    DP_EUC_INIT,
    DP_DIV_START,
    DP_DIV_STEP,
    DP_EUC_NEXT,
    DP_INV_SAVE,
    DP_RED_START,
    DP_POW_INIT,
    DP_SQR_START,
    DP_MULB_START,
    DP_R_SAVE,
    DP_BIT_NEXT,
    DP_PASS_SAVE
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_EUC_TEST,
    S_EUC_DIV,
    S_EUC_FIN,
    S_RED_START,
    S_RED_WAIT,
    S_POW_INIT,
    S_POW_BIT,
    S_SQR_WAIT,
    S_MUL_WAIT,
    S_POW_NEXT,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic       key_sel;
    logic [1:0] stage;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_last;
    logic r1_zero;
    logic gcd_one;
    logic p_small;
    logic exp_bit;
    logic bit_last;
  } dp_status_t;

  // (x + y) mod n for x, y below n; the carry bit keeps the sum exact.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] n);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[WIDTH-1:0];
  endfunction

endpackage

### src/three_pass_modexp_cipher_core.sv
// ----------------------------------------------------------------------------
// three_pass_modexp_cipher_core
// Shamir three-pass cipher: key inversion by extended Euclid, then four
// modular exponentiations of one message word.
// ----------------------------------------------------------------------------
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o   message_i
//   out      output     out_valid_o / out_stall_i pass_one_o .. recovered_o, key_error_o
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One word at a time. Each Euclid quotient is found one quotient bit per
// cycle; each exponent bit takes a squaring in the shared bit-serial
// multiplier, a further multiply for a one bit, and bookkeeping.
// Reset restores modulus 11 and exponents 3 and 7. A finished word waits in
// the output register, so the next word can be taken while out is stalled.
// ----------------------------------------------------------------------------
module three_pass_modexp_cipher_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tpmc_pkg::WIDTH-1:0] message_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tpmc_pkg::WIDTH-1:0] pass_one_o,
  output logic [tpmc_pkg::WIDTH-1:0] pass_two_o,
  output logic [tpmc_pkg::WIDTH-1:0] pass_three_o,
  output logic [tpmc_pkg::WIDTH-1:0] recovered_o,
  output logic                       key_error_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [tpmc_pkg::WIDTH-1:0] cfg_data_i
);
  import tpmc_pkg::*;

  logic [WIDTH-1:0] modulus_q, key_a_q, key_b_q;
  logic             out_valid_q;
  logic [WIDTH-1:0] p1_q, p2_q, p3_q, p4_q;
  logic             err_q;

  logic             idle, result_load;
  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [WIDTH-1:0] dp_p1, dp_p2, dp_p3, dp_p4;
  logic             dp_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= WIDTH'(11);
      key_a_q   <= WIDTH'(3);
      key_b_q   <= WIDTH'(7);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODULUS: modulus_q <= cfg_data_i;
        REG_KEY_A:   key_a_q   <= cfg_data_i;
        REG_KEY_B:   key_b_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpmc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_valid_i),
    .idle_o        (idle),
    .out_full_i    (out_valid_q),
    .result_load_o (result_load),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  tpmc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .modulus_i    (modulus_q),
    .key_a_exp_i  (key_a_q),
    .key_b_exp_i  (key_b_q),
    .message_i    (message_i),
    .pass_one_o   (dp_p1),
    .pass_two_o   (dp_p2),
    .pass_three_o (dp_p3),
    .recovered_o  (dp_p4),
    .key_error_o  (dp_err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_load) begin
      p1_q  <= dp_p1;
      p2_q  <= dp_p2;
      p3_q  <= dp_p3;
      p4_q  <= dp_p4;
      err_q <= dp_err;
    end
  end

  assign in_stall_o   = !idle;
  assign out_valid_o  = out_valid_q;
  assign pass_one_o   = p1_q;
  assign pass_two_o   = p2_q;
  assign pass_three_o = p3_q;
  assign recovered_o  = p4_q;
  assign key_error_o  = err_q;

endmodule

### src/tpmc_dp.sv
// ----------------------------------------------------------------------------
// tpmc_dp
// Datapath: bit-serial modular multiplier, bit-serial Euclid divider with
// cofactor update, exponent walker and the pass result registers.
// ----------------------------------------------------------------------------
module tpmc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tpmc_pkg::dp_cmd_t             cmd_i,
  output tpmc_pkg::dp_status_t          status_o,
  input  logic [tpmc_pkg::WIDTH-1:0]    modulus_i,
  input  logic [tpmc_pkg::WIDTH-1:0]    key_a_exp_i,
  input  logic [tpmc_pkg::WIDTH-1:0]    key_b_exp_i,
  input  logic [tpmc_pkg::WIDTH-1:0]    message_i,
  output logic [tpmc_pkg::WIDTH-1:0]    pass_one_o,
  output logic [tpmc_pkg::WIDTH-1:0]    pass_two_o,
  output logic [tpmc_pkg::WIDTH-1:0]    pass_three_o,
  output logic [tpmc_pkg::WIDTH-1:0]    recovered_o,
  output logic                          key_error_o
);
  import tpmc_pkg::*;

  logic [WIDTH-1:0] msg_q, p_q, n_q, ka_q, kb_q, inv_a_q, inv_b_q;
  logic [WIDTH-1:0] base_q, exp_q, r_q;
  logic [CNT_W-1:0] bit_cnt_q;
  logic [WIDTH-1:0] pass_q [4];
  logic             err_q;

  // Euclid registers.
  logic [WIDTH-1:0] r0_q, r1_q, t0_q, t1_q, work_q, rem_q, acc_q;
  logic [CNT_W-1:0] div_cnt_q;

  // Multiplier registers.
  logic [WIDTH-1:0] mul_a_q, mul_b_q, mul_r_q;
  logic [CNT_W-1:0] mul_cnt_q;
  logic             mul_busy_q;

  logic [WIDTH:0]   rem_sh;
  logic             q_bit;
  logic [WIDTH-1:0] rem_d, acc_dbl, acc_d, neg_acc, t2;
  logic [WIDTH-1:0] mul_dbl, mul_r_d;
  logic [WIDTH-1:0] exp_sel;

  // One quotient bit per cycle; the quotient times t1 is accumulated mod n
  // in Horner order alongside it.
  always_comb begin
    rem_sh  = {rem_q, work_q[WIDTH-1]};
    q_bit   = (rem_sh >= {1'b0, r1_q});
    rem_d   = q_bit ? WIDTH'(rem_sh - {1'b0, r1_q}) : rem_sh[WIDTH-1:0];
    acc_dbl = add_mod(acc_q, acc_q, n_q);
    acc_d   = q_bit ? add_mod(acc_dbl, t1_q, n_q) : acc_dbl;
    neg_acc = (acc_q == '0) ? '0 : n_q - acc_q;
    t2      = add_mod(t0_q, neg_acc, n_q);
  end

  always_comb begin
    mul_dbl = add_mod(mul_r_q, mul_r_q, p_q);
    mul_r_d = mul_b_q[WIDTH-1] ? add_mod(mul_dbl, mul_a_q, p_q) : mul_dbl;
  end

  always_comb begin
    case (cmd_i.stage)
      2'd0:    exp_sel = ka_q;
      2'd1:    exp_sel = kb_q;
      2'd2:    exp_sel = inv_a_q;
      default: exp_sel = inv_b_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mul_cnt_q  <= '0;
    end else begin
      if (cmd_i.op == DP_RED_START || cmd_i.op == DP_SQR_START ||
          cmd_i.op == DP_MULB_START) begin
        mul_busy_q <= 1'b1;
        mul_cnt_q  <= CNT_W'(WIDTH - 1);
      end else if (mul_busy_q) begin
        mul_cnt_q <= mul_cnt_q - 1'b1;
        if (mul_cnt_q == '0) begin
          mul_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_RED_START: begin
        mul_a_q <= WIDTH'(1);
        mul_b_q <= msg_q;
        mul_r_q <= '0;
      end
      DP_SQR_START: begin
        mul_a_q <= r_q;
        mul_b_q <= r_q;
        mul_r_q <= '0;
      end
      DP_MULB_START: begin
        mul_a_q <= base_q;
        mul_b_q <= mul_r_q;
        mul_r_q <= '0;
      end
      default: begin
        if (mul_busy_q) begin
          mul_r_q <= mul_r_d;
          mul_b_q <= {mul_b_q[WIDTH-2:0], 1'b0};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        msg_q <= message_i;
        p_q   <= modulus_i;
        n_q   <= modulus_i - 1'b1;
        ka_q  <= key_a_exp_i;
        kb_q  <= key_b_exp_i;
      end
      DP_EUC_INIT: begin
        r0_q <= n_q;
        r1_q <= (cmd_i.key_sel == KEY_SEL_B) ? kb_q : ka_q;
        t0_q <= '0;
        t1_q <= WIDTH'(1);
      end
      DP_DIV_START: begin
        work_q    <= r0_q;
        rem_q     <= '0;
        acc_q     <= '0;
        div_cnt_q <= CNT_W'(WIDTH - 1);
      end
      DP_DIV_STEP: begin
        work_q    <= {work_q[WIDTH-2:0], 1'b0};
        rem_q     <= rem_d;
        acc_q     <= acc_d;
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      DP_EUC_NEXT: begin
        r0_q <= r1_q;
        r1_q <= rem_q;
        t0_q <= t1_q;
        t1_q <= t2;
      end
      DP_INV_SAVE: begin
        if (cmd_i.key_sel == KEY_SEL_B) begin
          inv_b_q <= t0_q;
        end else begin
          inv_a_q <= t0_q;
        end
      end
      DP_POW_INIT: begin
        base_q    <= (cmd_i.stage == STAGE_FIRST) ? mul_r_q : r_q;
        exp_q     <= exp_sel;
        r_q       <= WIDTH'(1);
        bit_cnt_q <= CNT_W'(WIDTH - 1);
      end
      DP_R_SAVE: r_q <= mul_r_q;
      DP_BIT_NEXT: begin
        exp_q     <= {exp_q[WIDTH-2:0], 1'b0};
        bit_cnt_q <= bit_cnt_q - 1'b1;
      end
      DP_PASS_SAVE: pass_q[cmd_i.stage] <= r_q;
      DP_ERROR: begin
        pass_q[0] <= '0;
        pass_q[1] <= '0;
        pass_q[2] <= '0;
        pass_q[3] <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else if (cmd_i.op == DP_LOAD) begin
      err_q <= 1'b0;
    end else if (cmd_i.op == DP_ERROR) begin
      err_q <= 1'b1;
    end
  end

  assign status_o.mul_busy = mul_busy_q;
  assign status_o.div_last = (div_cnt_q == '0);
  assign status_o.r1_zero  = (r1_q == '0);
  assign status_o.gcd_one  = (r0_q == WIDTH'(1));
  assign status_o.p_small  = (p_q < WIDTH'(3));
  assign status_o.exp_bit  = exp_q[WIDTH-1];
  assign status_o.bit_last = (bit_cnt_q == '0);

  assign pass_one_o   = pass_q[0];
  assign pass_two_o   = pass_q[1];
  assign pass_three_o = pass_q[2];
  assign recovered_o  = pass_q[3];
  assign key_error_o  = err_q;

endmodule

### src/tpmc_ctrl.sv
// ----------------------------------------------------------------------------
// tpmc_ctrl
// Controller: sequences key checks, inversions and the four exponentiations.
// ----------------------------------------------------------------------------
module tpmc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  idle_o,
  input  logic                  out_full_i,
  output logic                  result_load_o,
  output tpmc_pkg::dp_cmd_t     cmd_o,
  input  tpmc_pkg::dp_status_t  status_i
);
  import tpmc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        key_q, key_d;
  logic [1:0]  stage_q, stage_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      key_q   <= KEY_SEL_A;
      stage_q <= STAGE_FIRST;
    end else begin
      state_q <= state_d;
      key_q   <= key_d;
      stage_q <= stage_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    key_d         = key_q;
    stage_d       = stage_q;
    cmd_o.op      = DP_NOP;
    cmd_o.key_sel = key_q;
    cmd_o.stage   = stage_q;
    result_load_o = 1'b0;
    idle_o        = 1'b0;
    case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.p_small) begin
          cmd_o.op = DP_ERROR;
          state_d  = S_DONE;
        end else begin
          cmd_o.op      = DP_EUC_INIT;
          cmd_o.key_sel = KEY_SEL_A;
          key_d         = KEY_SEL_A;
          state_d       = S_EUC_TEST;
        end
      end
      S_EUC_TEST: begin
        if (!status_i.r1_zero) begin
          cmd_o.op = DP_DIV_START;
          state_d  = S_EUC_DIV;
        end else if (!status_i.gcd_one) begin
          cmd_o.op = DP_ERROR;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = DP_INV_SAVE;
          if (key_q == KEY_SEL_A) begin
            key_d   = KEY_SEL_B;
            state_d = S_EUC_FIN;
          end else begin
            state_d = S_RED_START;
          end
        end
      end
      S_EUC_DIV: begin
        cmd_o.op = DP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = S_EUC_FIN;
        end
      end
      S_EUC_FIN: begin
        // Either the end of one Euclid step or the switch to the second key.
        if (status_i.r1_zero && key_q == KEY_SEL_B && status_i.gcd_one) begin
          cmd_o.op = DP_EUC_INIT;
          state_d  = S_EUC_TEST;
        end else begin
          cmd_o.op = DP_EUC_NEXT;
          state_d  = S_EUC_TEST;
        end
        if (!status_i.r1_zero) begin
          cmd_o.op = DP_EUC_NEXT;
        end
        // A key without an inverse ends the word with an error.
        if (status_i.r1_zero && !status_i.gcd_one) begin
          cmd_o.op = DP_ERROR;
          state_d  = S_DONE;
        end
      end
      S_RED_START: begin
        // Message reduction starts the exponentiation phase.
        cmd_o.op = DP_RED_START;
        stage_d  = STAGE_FIRST;
        state_d  = S_RED_WAIT;
      end
      S_RED_WAIT: begin
        if (!status_i.mul_busy) begin
          cmd_o.op = DP_POW_INIT;
          state_d  = S_POW_BIT;
        end
      end
      S_POW_INIT: begin
        cmd_o.op = DP_POW_INIT;
        state_d  = S_POW_BIT;
      end
      S_POW_BIT: begin
        cmd_o.op = DP_SQR_START;
        state_d  = S_SQR_WAIT;
      end
      S_SQR_WAIT: begin
        if (!status_i.mul_busy) begin
          if (status_i.exp_bit) begin
            cmd_o.op = DP_MULB_START;
            state_d  = S_MUL_WAIT;
          end else begin
            cmd_o.op = DP_R_SAVE;
            state_d  = S_POW_NEXT;
          end
        end
      end
      S_MUL_WAIT: begin
        if (!status_i.mul_busy) begin
          cmd_o.op = DP_R_SAVE;
          state_d  = S_POW_NEXT;
        end
      end
      S_POW_NEXT: begin
        if (!status_i.bit_last) begin
          cmd_o.op = DP_BIT_NEXT;
          state_d  = S_POW_BIT;
        end else if (stage_q == STAGE_LAST) begin
          cmd_o.op = DP_PASS_SAVE;
          state_d  = S_DONE;
        end else begin
          // Save this pass; the next pass starts from r in the following cycle.
          cmd_o.op = DP_PASS_SAVE;
          stage_d  = stage_q + 1'b1;
          state_d  = S_POW_INIT;
        end
      end
      S_DONE: begin
        if (!out_full_i) begin
          result_load_o = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### src/tpmc_checker.sv
// ----------------------------------------------------------------------------
// tpmc_checker
// Port-level checks of the three-pass cipher core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpmc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [tpmc_pkg::WIDTH-1:0] pass_one_o,
  input logic [tpmc_pkg::WIDTH-1:0] pass_two_o,
  input logic [tpmc_pkg::WIDTH-1:0] pass_three_o,
  input logic [tpmc_pkg::WIDTH-1:0] recovered_o,
  input logic                       key_error_o
);

  logic in_take;
  logic passes_zero;

  assign in_take     = in_valid_i && !in_stall_o;
  assign passes_zero = (pass_one_o == '0) && (pass_two_o == '0) &&
                       (pass_three_o == '0) && (recovered_o == '0);

  // A stalled result word stays offered.
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // A rejected key gives an all-zero result word.
  `ASSERT_CLK(a_err_zero, (out_valid_o && key_error_o) |-> passes_zero, "passes with key error")

  // Once it has taken a word, the core stalls its input.
  `ASSERT_NEXT(a_busy_after_take, in_take, in_stall_o, "input not stalled after accept")

  // A result cannot appear in the cycle after taking a word.
  `ASSERT_NEXT(a_no_instant_result, in_take && !out_valid_o, !out_valid_o, "result too early")

endmodule

bind three_pass_modexp_cipher_core tpmc_checker u_tpmc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pass_one_o   (pass_one_o),
  .pass_two_o   (pass_two_o),
  .pass_three_o (pass_three_o),
  .recovered_o  (recovered_o),
  .key_error_o  (key_error_o)
);
